/* rtl/bsp_pkg.sv */
package bsp_pkg;

  // field widths fixed by the word format
  localparam int DATA_W = 32;

  typedef logic [1:0]               func_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [DATA_W-1:0] word_t;

  // operation codes
  localparam func_t FN_PUSH = 2'd0;
  localparam func_t FN_POP  = 2'd1;
  localparam func_t FN_PAL  = 2'd2;
  localparam func_t FN_DISP = 2'd3;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic    op_load;      // latch the incoming word
    logic    push_wr;      // write top entry and bump the count
    logic    cnt_dec;      // drop the top entry
    logic    ptr_init;     // low pointer to bottom, high pointer to top
    logic    ptr_step;     // low pointer up, high pointer down
    logic    rd_en;        // read both pointers into the read registers
    logic    out_load;     // load the result register
    status_t out_status;
    logic    out_use_data; // data from the high pointer read
    logic    out_pal;
    logic    out_last;
  } bsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t op;
    logic  full;
    logic  empty;
    logic  out_free;   // result register empty or being taken
    logic  pair_eq;    // registered reads match
    logic  pair_done;  // pointers met or are adjacent
    logic  bottom;     // high pointer at entry zero
  } bsp_stat_t;

endpackage

/* rtl/bsp_if.sv */
// input word: one operation
interface bsp_in_if;
  import bsp_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  word_t push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

// result word
interface bsp_out_if;
  import bsp_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  word_t   data_out;
  logic    is_palindrome;
  logic    last;

  modport source (output valid, output status, output data_out, output is_palindrome,
                  output last, input ready);
  modport sink   (input valid, input status, input data_out, input is_palindrome,
                  input last, output ready);
endinterface

/* rtl/bsp_datapath.sv */
module bsp_datapath #(
  parameter int STACK_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bsp_pkg::bsp_cmd_t cmd,
  output bsp_pkg::bsp_stat_t stat,
  input  bsp_pkg::func_t    in_func,
  input  bsp_pkg::word_t    in_push_value,
  output logic              out_valid,
  input  logic              out_ready,
  output bsp_pkg::status_t  out_status,
  output bsp_pkg::word_t    out_data_out,
  output logic              out_is_palindrome,
  output logic              out_last
);
  import bsp_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  // stack memory, reset value undefined
  word_t mem [STACK_DEPTH];

  func_t            op_r;
  word_t            val_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  word_t            rda_r, rdb_r;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r;
  word_t            out_data_r;
  logic             out_pal_r;
  logic             out_last_r;

  // latched operation
  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      op_r  <= in_func;
      val_r <= in_push_value;
    end
  end

  // fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push_wr) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // walk pointers
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.ptr_init) begin
      lo_nxt = '0;
      hi_nxt = IDX_W'(cnt_r - 1'b1);
    end else if (cmd.ptr_step) begin
      lo_nxt = IDX_W'(lo_r + 1'b1);
      hi_nxt = IDX_W'(hi_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  // memory write and registered reads
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem[cnt_r[IDX_W-1:0]] <= val_r;
    end
    if (cmd.rd_en) begin
      rda_r <= mem[lo_r];
      rdb_r <= mem[hi_r];
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_data_r   <= cmd.out_use_data ? rdb_r : '0;
      out_pal_r    <= cmd.out_pal;
      out_last_r   <= cmd.out_last;
    end
  end

  // status back to the controller
  assign stat.op        = op_r;
  assign stat.full      = (cnt_r == CNT_W'(STACK_DEPTH));
  assign stat.empty     = (cnt_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.pair_eq   = (rda_r == rdb_r);
  assign stat.pair_done = (lo_r == hi_r) || (IDX_W'(lo_r + 1'b1) == hi_r);
  assign stat.bottom    = (hi_r == '0);

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_data_out      = out_data_r;
  assign out_is_palindrome = out_pal_r;
  assign out_last          = out_last_r;

endmodule

/* rtl/bsp_ctrl.sv */
module bsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsp_pkg::bsp_stat_t stat,
  output bsp_pkg::bsp_cmd_t  cmd
);
  import bsp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PREAD = 3'd2;
  localparam logic [2:0] S_PCMP  = 3'd3;
  localparam logic [2:0] S_DREAD = 3'd4;
  localparam logic [2:0] S_DEMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       emit_last;

  // pop gives one word, display stops at the bottom entry
  assign emit_last = (stat.op == FN_POP) || stat.bottom;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op_load = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          FN_PUSH: begin
            if (stat.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = stat.full ? ST_OVERFLOW : ST_OK;
              cmd.push_wr    = !stat.full;
              state_nxt      = S_IDLE;
            end
          end
          FN_PAL: begin
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.ptr_init = 1'b1;
              state_nxt    = S_PREAD;
            end
          end
          default: begin
            // pop and display
            if (stat.empty) begin
              if (stat.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.ptr_init = 1'b1;
              cmd.cnt_dec  = (stat.op == FN_POP);
              state_nxt    = S_DREAD;
            end
          end
        endcase
      end
      S_PREAD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        if (stat.pair_eq && !stat.pair_done) begin
          cmd.ptr_step = 1'b1;
          state_nxt    = S_PREAD;
        end else if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_pal    = stat.pair_eq;
          state_nxt      = S_IDLE;
        end
      end
      S_DREAD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DEMIT;
      end
      S_DEMIT: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_use_data = 1'b1;
          cmd.out_last     = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ptr_step = 1'b1;
            state_nxt    = S_DREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/bounded_stack_with_palindrome_check.sv */
// Channel  Dir  Fields                                     Handshake
// in_ch    in   func[1:0], push_value[31:0] signed         valid/ready
// out_ch   out  status[1:0], data_out[31:0] signed,        valid/ready
//               is_palindrome, last
//
// One operation at a time; the controller walks the stack memory through
// its two registered read ports. Push needs no read. Pop and display read
// each entry before emitting it, display from the top to the bottom entry;
// check compares pairs from both ends inward, stopping early on a mismatch.
// Synchronous active-low reset empties the stack; memory contents are kept.
// A stalled result holds the walk in place; the next operation is taken
// while the final result still waits in the output register.
module bounded_stack_with_palindrome_check #(
  parameter int STACK_DEPTH = 8
) (
  input logic        clk,
  input logic        rst_n,
  bsp_in_if.sink     in_ch,
  bsp_out_if.source  out_ch
);
  import bsp_pkg::*;

  bsp_cmd_t  cmd;
  bsp_stat_t stat;

  // controller
  bsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack memory, pointers and result register
  bsp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_ch.func),
    .in_push_value     (in_ch.push_value),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_data_out      (out_ch.data_out),
    .out_is_palindrome (out_ch.is_palindrome),
    .out_last          (out_ch.last)
  );

endmodule

/* rtl/bsp_checker.sv */
module bsp_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input bsp_pkg::status_t out_status,
  input bsp_pkg::word_t   out_data_out,
  input logic             out_is_palindrome,
  input logic             out_last
);
  import bsp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out) && $stable(out_status))
    else $error("result word changed while stalled");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_OVERFLOW)
                  || (out_status == ST_EMPTY))
    else $error("undefined status code");

  // an error result is a lone final word with no data
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last && (out_data_out == '0)
                                           && !out_is_palindrome)
    else $error("error result carries data or is not final");

  // a palindrome flag only on a final data-free word
  a_pal_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_palindrome |-> out_last && (out_data_out == '0))
    else $error("palindrome flag on a data word");

  // the block is busy in the cycle after taking an operation
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second operation taken back to back");

endmodule

bind bounded_stack_with_palindrome_check bsp_checker u_bsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_data_out      (out_ch.data_out),
  .out_is_palindrome (out_ch.is_palindrome),
  .out_last          (out_ch.last)
);
